FILE: hw/rtl/dlts_pkg.sv
package dlts_pkg;

	localparam int TIMERS     = 8;
	localparam int SLOTS      = 8;
	localparam int MAX_RES    = 8;
	localparam int MS_PER_SEC = 1000;

	localparam int IDX_W   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int LEN_W   = $clog2(TIMERS + 1);
	localparam int SLOT_W  = 3;
	localparam int DELTA_W = 15;
	localparam int OFS_W   = 8;
	localparam int PER_W   = 8;
	localparam int MS_W    = 10;
	localparam int SEC_W   = 16;
	localparam int RES_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;

	localparam logic FUNC_MS  = 1'b0;
	localparam logic FUNC_REG = 1'b1;

	localparam logic [1:0] KIND_STATUS  = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_MILLIS  = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_ZERO_TICKS = 2'd1;
	localparam logic [1:0] ST_SLOT_BUSY  = 2'd2;
	localparam logic [1:0] ST_EVERY_TICK = 2'd3;

	typedef struct packed {
		logic             tick;
		logic [MS_W-1:0]  millis;
		logic [SEC_W-1:0] seconds;
	} time_status_t;

	typedef struct packed {
		logic               a_gt_b;
		logic [DELTA_W-1:0] a_minus_b;
		logic [DELTA_W-1:0] b_minus_a;
	} alu_result_t;

endpackage

FILE: hw/rtl/dlts_delta_alu.sv
module dlts_delta_alu (
	input  logic [dlts_pkg::DELTA_W-1:0] a,
	input  logic [dlts_pkg::DELTA_W-1:0] b,
	output dlts_pkg::alu_result_t        res
);

	logic [dlts_pkg::DELTA_W:0] diff;

	assign diff = {1'b0, a} - {1'b0, b};

	assign res.a_gt_b    = !diff[dlts_pkg::DELTA_W] && (diff != '0);
	assign res.a_minus_b = diff[dlts_pkg::DELTA_W-1:0];
	assign res.b_minus_a = b - a;

endmodule

FILE: hw/rtl/dlts_timebase.sv
module dlts_timebase (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [dlts_pkg::PER_W-1:0]  period,
	output dlts_pkg::time_status_t      ts
);

	logic [dlts_pkg::MS_W-1:0]  ms_q;
	logic [dlts_pkg::SEC_W-1:0] sec_q;
	logic [dlts_pkg::PER_W-1:0] div_q;
	logic [dlts_pkg::MS_W-1:0]  ms_inc;
	logic [dlts_pkg::PER_W-1:0] div_inc;

	assign ms_inc  = ms_q + 1'b1;
	assign div_inc = div_q + 1'b1;

	// tick is valid in the cycle a millisecond is taken
	assign ts.tick    = (period != '0) && (div_inc >= period);
	assign ts.millis  = ms_q;
	assign ts.seconds = sec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q  <= '0;
			sec_q <= '0;
			div_q <= '0;
		end else if (step) begin
			if (ms_inc >= dlts_pkg::MS_W'(dlts_pkg::MS_PER_SEC)) begin
				ms_q  <= '0;
				sec_q <= sec_q + 1'b1;
			end else begin
				ms_q <= ms_inc;
			end
			if (period != '0) begin
				div_q <= ts.tick ? '0 : div_inc;
			end
		end
	end

endmodule

FILE: hw/rtl/delta_list_timer_scheduler.sv
// Delta-list timer scheduler.
// Input word: pulse start while busy is low. func selects one elapsed
// millisecond or a timer registration (timer_slot, period_ticks, repeating,
// first_offset). tick_period_ms is written with tick_period_we at any idle time.
// Each result word is held for one cycle with result_strobe high; last
// marks the final word of an input. The receiver cannot stall: every word
// is presented exactly once.
// A rejected registration, a millisecond without a system tick, or one with
// an empty queue answers in the next cycle and leaves the block ready. An
// accepted registration walks the delta queue through the shared
// subtract/compare unit, one entry per cycle. A millisecond with a system
// tick and a non-empty queue counts the head down and then checks it; with
// no timer due it answers with one millisecond word, else per expired timer
// it pops the head, re-inserts a repeating timer with a walk, and emits one
// result word; at most 8 expiries per millisecond.
// Reset clears counters, divider, tick period, queue length and all slot
// active flags; the block is ready right after reset.
module delta_list_timer_scheduler (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           tick_period_we,
	input  logic [dlts_pkg::PER_W-1:0]     tick_period_ms,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [dlts_pkg::SLOT_W-1:0]    timer_slot,
	input  logic [dlts_pkg::DELTA_W-1:0]   period_ticks,
	input  logic                           repeating,
	input  logic [dlts_pkg::OFS_W-1:0]     first_offset,
	output logic                           result_strobe,
	output logic [1:0]                     kind,
	output logic [1:0]                     status,
	output logic [dlts_pkg::SLOT_W-1:0]    expired_slot,
	output logic                           system_tick,
	output logic [dlts_pkg::MS_W-1:0]      millis,
	output logic [dlts_pkg::SEC_W-1:0]     seconds,
	output logic                           last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_CHECK,
		S_POP,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [dlts_pkg::PER_W-1:0]   period_q;
	logic [dlts_pkg::SLOT_W-1:0]  q_slot_q  [dlts_pkg::TIMERS];
	logic [dlts_pkg::DELTA_W-1:0] q_delta_q [dlts_pkg::TIMERS];
	logic [dlts_pkg::DELTA_W-1:0] slot_period_q [dlts_pkg::SLOTS];
	logic                         slot_rep_q    [dlts_pkg::SLOTS];
	logic [dlts_pkg::SLOTS-1:0]   slot_active_q;
	logic [dlts_pkg::LEN_W-1:0]   len_q;

	logic [dlts_pkg::DELTA_W-1:0] t_q;
	logic [dlts_pkg::LEN_W-1:0]   i_q;
	logic [dlts_pkg::SLOT_W-1:0]  s_q;
	logic                         reg_q;
	logic [dlts_pkg::RES_W-1:0]   n_q;

	logic                         strobe_q;
	logic [1:0]                   kind_q;
	logic [1:0]                   status_q;
	logic [dlts_pkg::SLOT_W-1:0]  xslot_q;
	logic                         tick_q;
	logic                         last_q;

	logic                         accept;
	logic                         ms_step;
	dlts_pkg::time_status_t       ts;
	dlts_pkg::alu_result_t        alu;
	logic [dlts_pkg::DELTA_W-1:0] alu_a;
	logic [dlts_pkg::DELTA_W-1:0] alu_b;
	logic [dlts_pkg::DELTA_W-1:0] delta_at_i;
	logic                         i_in_queue;
	logic [dlts_pkg::DELTA_W-1:0] first_ticks;
	logic [1:0]                   reg_status;
	logic [dlts_pkg::SLOT_W-1:0]  head_slot;
	logic                         head_due;
	logic                         head_due_after_pop;

	assign accept  = start && (state_q == S_IDLE);
	assign ms_step = accept && (func == dlts_pkg::FUNC_MS);
	assign busy    = (state_q != S_IDLE);

	dlts_timebase u_timebase (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (ms_step),
		.period (period_q),
		.ts     (ts)
	);

	assign i_in_queue = (i_q < len_q);
	assign delta_at_i = q_delta_q[i_q[dlts_pkg::IDX_W-1:0]];

	// queue walk in S_WALK, head countdown inputs in every other state
	always_comb begin
		if (state_q == S_WALK) begin
			alu_a = t_q;
			alu_b = delta_at_i;
		end else begin
			alu_a = q_delta_q[0];
			alu_b = dlts_pkg::DELTA_W'(1);
		end
	end

	dlts_delta_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.res (alu)
	);

	assign first_ticks = (first_offset != '0) ?
		dlts_pkg::DELTA_W'(first_offset) : period_ticks;
	assign head_slot   = q_slot_q[0];
	assign head_due    = (len_q != '0) && (q_delta_q[0] == '0);
	assign head_due_after_pop = head_due && (n_q != dlts_pkg::RES_W'(dlts_pkg::MAX_RES - 1));

	always_comb begin
		if (period_ticks == dlts_pkg::DELTA_W'(1) && !repeating) begin
			reg_status = dlts_pkg::ST_EVERY_TICK;
		end else if (first_ticks == '0) begin
			reg_status = dlts_pkg::ST_ZERO_TICKS;
		end else if (slot_active_q[timer_slot] ||
				len_q >= dlts_pkg::LEN_W'(dlts_pkg::TIMERS)) begin
			reg_status = dlts_pkg::ST_SLOT_BUSY;
		end else begin
			reg_status = dlts_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (tick_period_we) begin
			period_q <= tick_period_ms;
		end
	end

	// queue storage and slot data: payload, no reset
	always_ff @(posedge clk) begin
		if (accept && func == dlts_pkg::FUNC_REG && reg_status == dlts_pkg::ST_OK) begin
			slot_period_q[timer_slot] <= period_ticks;
			slot_rep_q[timer_slot]    <= repeating;
		end
		if (ms_step && ts.tick && len_q != '0 && q_delta_q[0] != '0) begin
			q_delta_q[0] <= alu.a_minus_b;
		end
		if (state_q == S_WALK && !(i_in_queue && alu.a_gt_b)) begin
			for (int j = 0; j < dlts_pkg::TIMERS; j++) begin
				if (dlts_pkg::LEN_W'(j) == i_q) begin
					q_slot_q[j]  <= s_q;
					q_delta_q[j] <= t_q;
				end else if (j > 0 && dlts_pkg::LEN_W'(j) > i_q) begin
					q_slot_q[j] <= q_slot_q[j-1];
					if (dlts_pkg::LEN_W'(j - 1) == i_q) begin
						q_delta_q[j] <= alu.b_minus_a;
					end else begin
						q_delta_q[j] <= q_delta_q[j-1];
					end
				end
			end
		end
		if (state_q == S_POP) begin
			for (int j = 0; j < dlts_pkg::TIMERS - 1; j++) begin
				q_slot_q[j]  <= q_slot_q[j+1];
				q_delta_q[j] <= q_delta_q[j+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			slot_active_q <= '0;
			len_q         <= '0;
			t_q           <= '0;
			i_q           <= '0;
			s_q           <= '0;
			reg_q         <= 1'b0;
			n_q           <= '0;
			strobe_q      <= 1'b0;
			kind_q        <= dlts_pkg::KIND_STATUS;
			status_q      <= dlts_pkg::ST_OK;
			xslot_q       <= '0;
			tick_q        <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && func == dlts_pkg::FUNC_REG) begin
						if (reg_status == dlts_pkg::ST_OK) begin
							slot_active_q[timer_slot] <= 1'b1;
							t_q     <= first_ticks;
							i_q     <= '0;
							s_q     <= timer_slot;
							reg_q   <= 1'b1;
							state_q <= S_WALK;
						end else begin
							strobe_q <= 1'b1;
							kind_q   <= dlts_pkg::KIND_STATUS;
							status_q <= reg_status;
							xslot_q  <= '0;
							tick_q   <= 1'b0;
							last_q   <= 1'b1;
						end
					end else if (ms_step) begin
						if (ts.tick && len_q != '0) begin
							n_q     <= '0;
							state_q <= S_CHECK;
						end else begin
							strobe_q <= 1'b1;
							kind_q   <= dlts_pkg::KIND_MILLIS;
							status_q <= dlts_pkg::ST_OK;
							xslot_q  <= '0;
							tick_q   <= ts.tick;
							last_q   <= 1'b1;
						end
					end
				end
				S_WALK: begin
					if (i_in_queue && alu.a_gt_b) begin
						t_q <= alu.a_minus_b;
						i_q <= i_q + 1'b1;
					end else begin
						len_q <= len_q + 1'b1;
						if (reg_q) begin
							strobe_q <= 1'b1;
							kind_q   <= dlts_pkg::KIND_STATUS;
							status_q <= dlts_pkg::ST_OK;
							xslot_q  <= '0;
							tick_q   <= 1'b0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_CHECK: begin
					if (head_due) begin
						state_q <= S_POP;
					end else begin
						strobe_q <= 1'b1;
						kind_q   <= dlts_pkg::KIND_MILLIS;
						status_q <= dlts_pkg::ST_OK;
						xslot_q  <= '0;
						tick_q   <= 1'b1;
						last_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_POP: begin
					s_q   <= head_slot;
					len_q <= len_q - 1'b1;
					if (slot_rep_q[head_slot] && slot_period_q[head_slot] != '0) begin
						t_q     <= slot_period_q[head_slot];
						i_q     <= '0;
						reg_q   <= 1'b0;
						state_q <= S_WALK;
					end else begin
						slot_active_q[head_slot] <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					strobe_q <= 1'b1;
					kind_q   <= dlts_pkg::KIND_EXPIRED;
					status_q <= dlts_pkg::ST_OK;
					xslot_q  <= s_q;
					tick_q   <= 1'b1;
					last_q   <= !head_due_after_pop;
					n_q      <= n_q + 1'b1;
					state_q  <= head_due_after_pop ? S_POP : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign status        = status_q;
	assign expired_slot  = xslot_q;
	assign system_tick   = tick_q;
	assign millis        = ts.millis;
	assign seconds       = ts.seconds;
	assign last          = last_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= dlts_pkg::LEN_W'(dlts_pkg::TIMERS))
		else $error("queue length beyond capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> i_q <= len_q)
		else $error("walk index past queue end");

	a_reg_answer: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == dlts_pkg::FUNC_REG |=> result_strobe || state_q == S_WALK)
		else $error("registration neither answered nor inserted");

	a_expiry_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && kind == dlts_pkg::KIND_EXPIRED |-> system_tick)
		else $error("expiry reported without system tick");

	a_pop_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> slot_active_q[head_slot])
		else $error("queued slot not active");

endmodule

FILE: verif/tb_delta_list_timer_scheduler.sv
module tb_delta_list_timer_scheduler;
	import dlts_pkg::*;

	localparam int STALL_LIMIT = 3000;

	typedef struct {
		logic               func;
		logic [SLOT_W-1:0]  slot;
		logic [DELTA_W-1:0] period;
		logic               rep;
		logic [OFS_W-1:0]   offset;
	} word_t;

	typedef struct {
		logic [1:0]        kind;
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic              tick;
		logic [MS_W-1:0]   millis;
		logic [SEC_W-1:0]  seconds;
		logic              last;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tick_period_we = 1'b0;
	logic [PER_W-1:0] tick_period_ms = '0;
	logic start = 1'b0;
	logic func = FUNC_MS;
	logic [SLOT_W-1:0] timer_slot = '0;
	logic [DELTA_W-1:0] period_ticks = '0;
	logic repeating = 1'b0;
	logic [OFS_W-1:0] first_offset = '0;
	logic busy;
	logic result_strobe;
	logic [1:0] kind;
	logic [1:0] status;
	logic [SLOT_W-1:0] expired_slot;
	logic system_tick;
	logic [MS_W-1:0] millis;
	logic [SEC_W-1:0] seconds;
	logic last;

	delta_list_timer_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick_period_we(tick_period_we),
		.tick_period_ms(tick_period_ms),
		.start(start),
		.busy(busy),
		.func(func),
		.timer_slot(timer_slot),
		.period_ticks(period_ticks),
		.repeating(repeating),
		.first_offset(first_offset),
		.result_strobe(result_strobe),
		.kind(kind),
		.status(status),
		.expired_slot(expired_slot),
		.system_tick(system_tick),
		.millis(millis),
		.seconds(seconds),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// scheduler image kept in step with the block
	logic [PER_W-1:0]   cfg_period = '0;
	logic [MS_W-1:0]    ms_now = '0;
	logic [SEC_W-1:0]   sec_now = '0;
	logic [PER_W-1:0]   divider = '0;
	logic [SLOT_W-1:0]  q_slot [TIMERS];
	logic [DELTA_W-1:0] q_delta [TIMERS];
	int                 q_len = 0;
	logic [DELTA_W-1:0] slot_per [SLOTS];
	logic               slot_rep [SLOTS];
	logic               slot_on [SLOTS] = '{default: 1'b0};

	word_t    pending_words [$];
	outcome_t results_due [$];
	word_t    on_port;
	int       burst_left = 0;
	int       gap_left = 0;
	int       mismatches = 0;
	int       stall_cycles = 0;

	function automatic word_t mk(input logic f, input logic [SLOT_W-1:0] s,
			input logic [DELTA_W-1:0] p, input logic r, input logic [OFS_W-1:0] o);
		word_t w;
		w.func = f;
		w.slot = s;
		w.period = p;
		w.rep = r;
		w.offset = o;
		return w;
	endfunction

	function automatic outcome_t outcome(input logic [1:0] k, input logic [1:0] st,
			input logic [SLOT_W-1:0] s, input logic t);
		outcome_t o;
		o.kind = k;
		o.status = st;
		o.slot = s;
		o.tick = t;
		o.millis = ms_now;
		o.seconds = sec_now;
		o.last = 1'b0;
		return o;
	endfunction

	// equal deadlines go in front of the entries already there
	task automatic delta_insert(input logic [SLOT_W-1:0] s, input logic [DELTA_W-1:0] ticks);
		int i;
		int j;
		logic [DELTA_W-1:0] t;
		t = ticks;
		i = 0;
		if (q_len >= TIMERS)
			return;
		while (i < q_len && t > q_delta[i]) begin
			t = t - q_delta[i];
			i++;
		end
		if (i < q_len)
			q_delta[i] = q_delta[i] - t;
		for (j = q_len; j > i; j--) begin
			q_slot[j] = q_slot[j-1];
			q_delta[j] = q_delta[j-1];
		end
		q_slot[i] = s;
		q_delta[i] = t;
		q_len++;
	endtask

	task automatic schedule_word(input word_t w);
		logic [DELTA_W-1:0] first;
		logic [1:0] st;
		logic [SLOT_W-1:0] s;
		logic tick;
		int n;
		int j;
		outcome_t tail;
		if (w.func == FUNC_REG) begin
			first = (w.offset != 0) ? DELTA_W'(w.offset) : w.period;
			if (w.period == 1 && !w.rep)
				st = ST_EVERY_TICK;
			else if (first == 0)
				st = ST_ZERO_TICKS;
			else if (slot_on[w.slot] || q_len >= TIMERS)
				st = ST_SLOT_BUSY;
			else begin
				st = ST_OK;
				slot_per[w.slot] = w.period;
				slot_rep[w.slot] = w.rep;
				slot_on[w.slot] = 1'b1;
				delta_insert(w.slot, first);
			end
			results_due.push_back(outcome(KIND_STATUS, st, '0, 1'b0));
		end else begin
			ms_now = ms_now + 1'b1;
			if (ms_now >= MS_PER_SEC) begin
				ms_now = '0;
				sec_now = sec_now + 1'b1;
			end
			tick = 1'b0;
			if (cfg_period != 0) begin
				divider = divider + 1'b1;
				if (divider >= cfg_period) begin
					divider = '0;
					tick = 1'b1;
				end
			end
			n = 0;
			if (tick && q_len > 0) begin
				if (q_delta[0] > 0)
					q_delta[0] = q_delta[0] - 1'b1;
				while (q_len > 0 && q_delta[0] == 0 && n < MAX_RES) begin
					s = q_slot[0];
					for (j = 1; j < q_len; j++) begin
						q_slot[j-1] = q_slot[j];
						q_delta[j-1] = q_delta[j];
					end
					q_len--;
					if (slot_rep[s] && slot_per[s] != 0)
						delta_insert(s, slot_per[s]);
					else
						slot_on[s] = 1'b0;
					results_due.push_back(outcome(KIND_EXPIRED, ST_OK, s, 1'b1));
					n++;
				end
			end
			if (n == 0)
				results_due.push_back(outcome(KIND_MILLIS, ST_OK, '0, tick));
		end
		tail = results_due.pop_back();
		tail.last = 1'b1;
		results_due.push_back(tail);
	endtask

	function automatic word_t random_word();
		logic [SLOT_W-1:0] s;
		logic r;
		s = SLOT_W'($urandom_range(0, SLOTS - 1));
		r = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 99) < 65)
			return mk(FUNC_MS, s, DELTA_W'($urandom_range(0, 32767)), r,
				OFS_W'($urandom_range(0, 255)));
		case ($urandom_range(0, 9))
			0: return mk(FUNC_REG, s, 1, 1'b0, OFS_W'($urandom_range(0, 255)));
			1: return mk(FUNC_REG, s, 0, r, 0);
			2: return mk(FUNC_REG, s, DELTA_W'($urandom_range(0, 32767)), r,
					OFS_W'($urandom_range(0, 255)));
			default: return mk(FUNC_REG, s, DELTA_W'($urandom_range(0, 6)), r,
					OFS_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 5)));
		endcase
	endfunction

	task automatic wait_quiet();
		while (pending_words.size() != 0 || start || results_due.size() != 0)
			@(posedge clk);
		// let any trailing queue walk finish
		repeat (2 * TIMERS) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [PER_W-1:0] v);
		@(posedge clk);
		tick_period_we <= 1'b1;
		tick_period_ms <= v;
		@(posedge clk);
		tick_period_we <= 1'b0;
		cfg_period = v;
	endtask

	// sender: bursts of words with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				schedule_word(on_port);
			if (!start || !busy) begin
				if (gap_left > 0 || pending_words.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					start <= 1'b0;
				end else begin
					on_port = pending_words.pop_front();
					func <= on_port.func;
					timer_slot <= on_port.slot;
					period_ticks <= on_port.period;
					repeating <= on_port.rep;
					first_offset <= on_port.offset;
					start <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && result_strobe) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: kind %0d status %0d slot %0d ms %0d s %0d",
						kind, status, expired_slot, millis, seconds);
			end else begin
				want = results_due.pop_front();
				if (kind !== want.kind || status !== want.status ||
						expired_slot !== want.slot || system_tick !== want.tick ||
						millis !== want.millis || seconds !== want.seconds ||
						last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: kind %0d st %0d slot %0d tick %0d ms %0d s %0d last %0d",
							want.kind, want.status, want.slot, want.tick,
							want.millis, want.seconds, want.last);
						$display("         got: kind %0d st %0d slot %0d tick %0d ms %0d s %0d last %0d",
							kind, status, expired_slot, system_tick,
							millis, seconds, last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("no progress for %0d cycles", STALL_LIMIT);
			$display("tb_delta_list_timer_scheduler NOT OK");
			$finish;
		end
	end

	initial begin
		logic [PER_W-1:0] periods [7];
		periods = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd2, 8'd0, 8'd1};
		periods[5] = PER_W'($urandom_range(1, 255));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		write_period(1);

		pending_words.push_back(mk(FUNC_REG, 0, 1, 1'b0, 0));
		pending_words.push_back(mk(FUNC_REG, 1, 0, 1'b0, 0));
		pending_words.push_back(mk(FUNC_REG, 1, 0, 1'b1, 0));
		pending_words.push_back(mk(FUNC_REG, 2, 15'h7FFF, 1'b1, 8'd3));
		pending_words.push_back(mk(FUNC_REG, 2, 3, 1'b0, 2));
		// repeating with zero period drops out after one expiry
		pending_words.push_back(mk(FUNC_REG, 3, 0, 1'b1, 1));
		pending_words.push_back(mk(FUNC_REG, 4, 2, 1'b0, 8'hFF));
		// same deadline as slot 3, must fire ahead of it
		pending_words.push_back(mk(FUNC_REG, 5, 5, 1'b0, 1));
		pending_words.push_back(mk(FUNC_REG, 6, 2, 1'b1, 0));
		pending_words.push_back(mk(FUNC_REG, 7, 1, 1'b0, 3));
		pending_words.push_back(mk(FUNC_REG, 7, 15'h5555, 1'b0, 8'hAA));
		pending_words.push_back(mk(FUNC_REG, 0, 15'h2AAA, 1'b0, 8'h55));
		pending_words.push_back(mk(FUNC_REG, 1, 4, 1'b0, 2));
		// queue full and slot busy together
		pending_words.push_back(mk(FUNC_REG, 1, 4, 1'b1, 2));
		pending_words.push_back(mk(FUNC_MS, 7, 15'h7FFF, 1'b1, 8'hFF));
		repeat (9) pending_words.push_back(mk(FUNC_MS, 0, 0, 1'b0, 0));
		wait_quiet();

		foreach (periods[p]) begin
			write_period(periods[p]);
			repeat (9) pending_words.push_back(random_word());
			wait_quiet();
		end

		// timers still going under an odd tick period
		write_period(7);
		repeat (10) pending_words.push_back(random_word());
		wait_quiet();
		repeat (20) @(posedge clk);

		if (mismatches == 0 && results_due.size() == 0)
			$display("tb_delta_list_timer_scheduler OK");
		else
			$display("tb_delta_list_timer_scheduler NOT OK");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/dlts_pkg.sv
hw/rtl/dlts_delta_alu.sv
hw/rtl/dlts_timebase.sv
hw/rtl/delta_list_timer_scheduler.sv
verif/tb_delta_list_timer_scheduler.sv
